@@ rtl/ootc_pkg.sv @@
// Shared types and constants for the overlapping ones template counter.
// Holds the token that travels down the histogram cell row; no dependencies.
package ootc_pkg;

  localparam int TPL_W       = 5;
  localparam int BLK_W       = 16;
  localparam int MATCH_W     = 16;
  localparam int CLS_W       = 4;
  localparam int CLS_OUT_W   = 3;
  localparam int NUM_OUT_BINS = 6;
  localparam int BIN_OUT_W   = 24;
  localparam int BIN_EXT_W   = 32;

  localparam logic [TPL_W-1:0] TPL_MIN   = 5'd2;
  localparam logic [TPL_W-1:0] TPL_MAX   = 5'd21;
  localparam logic [TPL_W-1:0] TPL_RESET = 5'd9;
  localparam logic [BLK_W-1:0] BLK_RESET = 16'd1032;

  // Configuration register indexes
  localparam logic REG_TEMPLATE = 1'b0;
  localparam logic REG_BLOCK    = 1'b1;

  typedef logic [NUM_OUT_BINS-1:0][BIN_OUT_W-1:0] bins_t;

  // One finished block, or a clear that sweeps the bins as it passes
  typedef struct packed {
    logic               clr;
    logic [CLS_W-1:0]   cls;
    logic [MATCH_W-1:0] hits;
    bins_t              bin_vals;
  } tok_t;

endpackage

@@ rtl/ootc_front.sv @@
// Front stage: configuration registers, run-of-ones, block position and match counters.
// Emits one token per finished block or clear item; uses ootc_pkg.
module ootc_front
  import ootc_pkg::*;
#(
  parameter int TOP_CLASS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [BLK_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic              in_bit,
  output logic              in_ready,
  output logic              tok_valid,
  output tok_t              tok,
  input  logic              dn_ready
);

  logic [TPL_W-1:0]   tpl_r, tpl_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [TPL_W-1:0]   run_r, run_nxt;
  logic [BLK_W-1:0]   pos_r, pos_nxt;
  logic [MATCH_W-1:0] match_r, match_nxt;
  logic               tok_v_r, tok_v_nxt;
  tok_t               tok_r, tok_nxt;

  logic [TPL_W-1:0]   run_c;
  logic [TPL_W-1:0]   run_b;
  logic [MATCH_W-1:0] match_b;
  logic [BLK_W:0]     pos_inc;
  logic [BLK_W:0]     len;
  logic               blk_end;
  logic               accept;

  assign in_ready  = !tok_v_r || dn_ready;
  assign accept    = in_valid && in_ready;
  assign tok_valid = tok_v_r;
  assign tok       = tok_r;

  always_comb begin
    tpl_nxt = tpl_r;
    blk_nxt = blk_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_TEMPLATE: begin
          if (cfg_wdata[TPL_W-1:0] < TPL_MIN) begin
            tpl_nxt = TPL_MIN;
          end else if (cfg_wdata[TPL_W-1:0] > TPL_MAX) begin
            tpl_nxt = TPL_MAX;
          end else begin
            tpl_nxt = cfg_wdata[TPL_W-1:0];
          end
        end
        REG_BLOCK: blk_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    // clamp the run to a template that may have shrunk mid-block
    run_c   = (run_r > tpl_r) ? tpl_r : run_r;
    run_b   = '0;
    match_b = match_r;
    if (in_bit) begin
      run_b = (run_c < tpl_r) ? run_c + 1'b1 : run_c;
      if (run_b >= tpl_r && match_r != '1) begin
        match_b = match_r + 1'b1;
      end
    end
    pos_inc = {1'b0, pos_r} + 1'b1;
    len     = (blk_r == '0) ? {1'b1, {BLK_W{1'b0}}} : {1'b0, blk_r};
    blk_end = (pos_inc >= len);

    run_nxt   = run_r;
    pos_nxt   = pos_r;
    match_nxt = match_r;
    tok_v_nxt = tok_v_r;
    tok_nxt   = tok_r;
    if (in_ready) begin
      tok_v_nxt = 1'b0;
    end
    if (accept) begin
      tok_nxt = '0;
      if (in_kind) begin
        run_nxt     = '0;
        pos_nxt     = '0;
        match_nxt   = '0;
        tok_v_nxt   = 1'b1;
        tok_nxt.clr = 1'b1;
      end else if (blk_end) begin
        run_nxt      = '0;
        pos_nxt      = '0;
        match_nxt    = '0;
        tok_v_nxt    = 1'b1;
        tok_nxt.hits = match_b;
        tok_nxt.cls  = (match_b > MATCH_W'(TOP_CLASS)) ? CLS_W'(TOP_CLASS)
                                                       : match_b[CLS_W-1:0];
      end else begin
        run_nxt   = run_b;
        pos_nxt   = pos_inc[BLK_W-1:0];
        match_nxt = match_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpl_r   <= TPL_RESET;
      blk_r   <= BLK_RESET;
      run_r   <= '0;
      pos_r   <= '0;
      match_r <= '0;
      tok_v_r <= 1'b0;
    end else begin
      tpl_r   <= tpl_nxt;
      blk_r   <= blk_nxt;
      run_r   <= run_nxt;
      pos_r   <= pos_nxt;
      match_r <= match_nxt;
      tok_v_r <= tok_v_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

@@ rtl/ootc_cell.sv @@
// One histogram cell: owns bin IDX and one slot of the token row.
// Updates its bin as a token enters and stamps the new count; uses ootc_pkg.
module ootc_cell
  import ootc_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int BIN_WIDTH = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  input  tok_t up_tok,
  output logic up_ready,
  output logic dn_valid,
  output tok_t dn_tok,
  input  logic dn_ready
);

  localparam logic [BIN_WIDTH-1:0] BIN_MAX = '1;

  logic                 v_r;
  tok_t                 tok_r, tok_nxt;
  logic [BIN_WIDTH-1:0] bin_r, bin_nxt;
  logic [BIN_EXT_W-1:0] bin_ext;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

  always_comb begin
    bin_nxt = bin_r;
    if (up_tok.clr) begin
      bin_nxt = '0;
    end else if (up_tok.cls == CLS_W'(IDX) && bin_r != BIN_MAX) begin
      bin_nxt = bin_r + 1'b1;
    end
  end

  assign bin_ext = BIN_EXT_W'(bin_nxt);

  // stamp the updated count into the record; bins past the output set stay hidden
  if (IDX < NUM_OUT_BINS) begin : g_stamp
    always_comb begin
      tok_nxt               = up_tok;
      tok_nxt.bin_vals[IDX] = bin_ext[BIN_OUT_W-1:0];
    end
  end else begin : g_pass
    assign tok_nxt = up_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      bin_r <= '0;
    end else if (up_ready) begin
      v_r <= up_valid;
      if (up_valid) begin
        bin_r <= bin_nxt;
        tok_r <= tok_nxt;
      end
    end
  end

endmodule

@@ rtl/overlapping_ones_template_counter.sv @@
// Top level of the overlapping ones template counter.
// Uses ootc_pkg, ootc_front and a row of ootc_cell instances.
//
//  channel | dir | fields (low bit first)
//  --------+-----+-------------------------------------------------------------
//  in_*    | in  | tuser: kind; tdata: bit_value, 7 pad bits
//  out_*   | out | tdata: block_class, block_matches, bin_zero .. bin_many, pad
//  cfg_*   | in  | addr 0: template_length (clamped 2..21), 1: block_length
//
// One input transaction is taken per clock while in_tready is high. A data bit that does not close a
// block stays in the front counters; a closed block or a clear item becomes a
// token that advances one histogram cell per cycle while the cell ahead can
// take it. Each slot holds only while the slot ahead is full, so a stalled
// output stops the input once every slot is occupied. Synchronous active-low
// reset restores defaults.
module overlapping_ones_template_counter
  import ootc_pkg::*;
#(
  parameter int BIN_WIDTH = 24,
  parameter int TOP_CLASS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] bit_value, [7:1] zero
  input  logic [0:0]   in_tuser,   // [0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] block_class, [18:3] block_matches, [42:19] bin_zero,
  // [66:43] bin_one, [90:67] bin_two, [114:91] bin_three,
  // [138:115] bin_four, [162:139] bin_many, [167:163] zero
  output logic [167:0] out_tdata
);

  localparam int NUM_BINS = TOP_CLASS + 1;
  localparam int PAD_W    = 168 - (CLS_OUT_W + MATCH_W + NUM_OUT_BINS * BIN_OUT_W);

  // token row: index k feeds cell k, index NUM_BINS feeds the output register
  logic [NUM_BINS:0] row_valid;
  logic [NUM_BINS:0] row_ready;
  tok_t              row_tok [NUM_BINS+1];

  logic         out_valid_r;
  logic [167:0] out_data_r;

  ootc_front #(
    .TOP_CLASS (TOP_CLASS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_kind   (in_tuser[0]),
    .in_bit    (in_tdata[0]),
    .in_ready  (in_tready),
    .tok_valid (row_valid[0]),
    .tok       (row_tok[0]),
    .dn_ready  (row_ready[0])
  );

  for (genvar k = 0; k < NUM_BINS; k++) begin : g_cell
    ootc_cell #(
      .IDX       (k),
      .BIN_WIDTH (BIN_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (row_valid[k]),
      .up_tok   (row_tok[k]),
      .up_ready (row_ready[k]),
      .dn_valid (row_valid[k+1]),
      .dn_tok   (row_tok[k+1]),
      .dn_ready (row_ready[k+1])
    );
  end

  // output register: accept from the last cell whenever it is empty or draining
  assign row_ready[NUM_BINS] = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_ready[NUM_BINS]) begin
      // drop clear tokens here; they have swept every bin on the way
      out_valid_r <= row_valid[NUM_BINS] && !row_tok[NUM_BINS].clr;
      if (row_valid[NUM_BINS]) begin
        out_data_r <= {{PAD_W{1'b0}}, row_tok[NUM_BINS].bin_vals,
                       row_tok[NUM_BINS].hits,
                       row_tok[NUM_BINS].cls[CLS_OUT_W-1:0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ verif/ootc_tb_pkg.sv @@
`timescale 1ns / 100ps
// Item kinds shared by the template counter checker and testbench top.
// No dependencies.
package ootc_tb_pkg;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_CLEAR = 1'b1
  } item_kind_e;

endpackage

@@ verif/ootc_block_monitor.sv @@
`timescale 1ns / 100ps
// Watches the config port and both streams of the template counter, predicts
// every finished block and compares it field by field. Uses ootc_pkg, ootc_tb_pkg.
module ootc_block_monitor
  import ootc_pkg::*, ootc_tb_pkg::*;
#(
  parameter int BIN_WIDTH = 24,
  parameter int TOP_CLASS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_addr,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_tvalid,
  input  logic           in_tready,
  input  logic [7:0]     in_tdata,
  input  logic [0:0]     in_tuser,
  input  logic           out_tvalid,
  input  logic           out_tready,
  input  logic [167:0]   out_tdata,
  output int unsigned    mismatches,
  output int unsigned    pending
);

  typedef struct packed {
    logic [CLS_OUT_W-1:0] cls;
    logic [MATCH_W-1:0]   hits;
    bins_t                bin_vals;
  } block_stats_t;

  logic [TPL_W-1:0]     template_len;
  logic [BLK_W-1:0]     block_len;
  logic [TPL_W-1:0]     run_len;
  logic [BLK_W:0]       bits_in_block;
  logic [MATCH_W-1:0]   window_hits;
  logic [BIN_WIDTH-1:0] class_hist [TOP_CLASS+1];
  block_stats_t         blocks_due [$];
  int unsigned          results_seen;
  string bin_names [NUM_OUT_BINS] =
    '{"bin_zero", "bin_one", "bin_two", "bin_three", "bin_four", "bin_many"};

  function automatic void clear_statistics();
    run_len = '0;
    bits_in_block = '0;
    window_hits = '0;
    foreach (class_hist[j]) class_hist[j] = '0;
  endfunction

  function automatic void write_register(input logic addr, input logic [15:0] wdata);
    logic [TPL_W-1:0] t;
    if (addr == REG_TEMPLATE) begin
      t = wdata[TPL_W-1:0];
      if (t < TPL_MIN) t = TPL_MIN;
      else if (t > TPL_MAX) t = TPL_MAX;
      template_len = t;
    end else begin
      block_len = wdata[BLK_W-1:0];
    end
  endfunction

  // One data bit: advance the run of ones and close the block when full
  function automatic void count_window_bit(input logic b);
    int unsigned span;
    int unsigned cls;
    block_stats_t res;
    if (run_len > template_len) run_len = template_len;
    if (b) begin
      if (run_len < template_len) run_len++;
      if (run_len >= template_len && window_hits != '1) window_hits++;
    end else begin
      run_len = '0;
    end
    bits_in_block++;
    span = (block_len == '0) ? 32'd65536 : 32'(block_len);
    if (bits_in_block < span) return;
    cls = (window_hits > TOP_CLASS) ? TOP_CLASS : window_hits;
    if (class_hist[cls] != '1) class_hist[cls]++;
    res.cls = CLS_OUT_W'(cls);
    res.hits = window_hits;
    res.bin_vals = '0;
    for (int j = 0; j < NUM_OUT_BINS; j++) begin
      if (j <= TOP_CLASS) res.bin_vals[j] = BIN_OUT_W'(class_hist[j]);
    end
    blocks_due.push_back(res);
    run_len = '0;
    bits_in_block = '0;
    window_hits = '0;
  endfunction

  function automatic void report(input string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  function automatic void check_field(input string what, input longint want,
                                      input longint got);
    if (want != got)
      report($sformatf("block %0d %s: expected %0d, got %0d",
                       results_seen, what, want, got));
  endfunction

  function automatic void compare_result(input logic [167:0] word);
    block_stats_t want;
    if (blocks_due.size() == 0) begin
      report($sformatf("block %0d: result with no finished block due", results_seen));
    end else begin
      want = blocks_due.pop_front();
      check_field("block_class", want.cls, word[CLS_OUT_W-1:0]);
      check_field("block_matches", want.hits, word[CLS_OUT_W +: MATCH_W]);
      for (int j = 0; j < NUM_OUT_BINS; j++)
        check_field(bin_names[j], want.bin_vals[j],
                    word[CLS_OUT_W + MATCH_W + BIN_OUT_W*j +: BIN_OUT_W]);
    end
    results_seen++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      template_len = TPL_RESET;
      block_len = BLK_RESET;
      clear_statistics();
      blocks_due.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) write_register(cfg_addr, cfg_wdata);
      if (out_tvalid && out_tready) compare_result(out_tdata);
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == KIND_CLEAR) clear_statistics();
        else count_window_bit(in_tdata[0]);
      end
    end
    pending <= blocks_due.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for overlapping_ones_template_counter: drives bits, clears and
// config writes, and gives the verdict. Uses ootc_pkg, ootc_tb_pkg, ootc_block_monitor.
module tb
  import ootc_pkg::*, ootc_tb_pkg::*;
();

  localparam int BIN_W         = 24;
  localparam int TOP_CLS       = 5;
  // Settle time after the last due block, before touching config
  localparam int SETTLE_CYCLES = 2 * (TOP_CLS + 3);
  localparam int ITEM_TARGET   = 1750;
  localparam int IDLE_PCT      = 17;
  // Sender runs gap-free for this range of transactions
  localparam int QUIET_FROM    = 900;
  localparam int QUIET_TO      = 1300;
  // Receiver cycle windows: a long hold-off, then a stretch always ready
  localparam int HOLD_START    = 500;
  localparam int HOLD_CYCLES   = 300;
  localparam int STEADY_START  = 2200;
  localparam int STEADY_END    = 2700;
  // Short-block phase that spans the receiver hold-off
  localparam int PRESSURE_ITEMS = 500;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic         cfg_addr   = 1'b0;
  logic [15:0]  cfg_wdata  = '0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;   // [0] bit_value, [7:1] zero
  logic [0:0]   in_tuser   = '0;   // [0] kind
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [2:0] block_class, [18:3] block_matches, [42:19] bin_zero .. [162:139] bin_many
  logic [167:0] out_tdata;

  int unsigned  mismatches;
  int unsigned  pending;
  int unsigned  items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  overlapping_ones_template_counter #(
    .BIN_WIDTH (BIN_W),
    .TOP_CLASS (TOP_CLS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  ootc_block_monitor #(
    .BIN_WIDTH (BIN_W),
    .TOP_CLASS (TOP_CLS)
  ) monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Offer one transaction, with random idle cycles ahead of it outside the
  // quiet window; hold tvalid high across back-to-back transactions.
  task automatic send_item(input item_kind_e kind, input logic b);
    if (items_sent < QUIET_FROM || items_sent >= QUIET_TO) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, b};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Send data bits, lowest bit of the pattern first
  task automatic send_pattern(input logic [15:0] pattern, input int unsigned count);
    for (int k = 0; k < count; k++) send_item(KIND_DATA, pattern[k]);
  endtask

  // Drop valid, wait for every due block, then let the row empty of clears
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] tpl_word, input logic [15:0] blk_word);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TEMPLATE;
    cfg_wdata <= tpl_word;
    @(posedge clk);
    cfg_addr  <= REG_BLOCK;
    cfg_wdata <= blk_word;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random back-pressure, one long hold-off so the token row fills
  // and stalls the input, then a stretch with no stalls at all.
  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
        out_tready <= 1'b0;
      else if (cyc >= STEADY_START && cyc < STEADY_END)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [15:0] tpl_word;
    logic [15:0] blk_word;
    int unsigned pick;
    int unsigned burst;
    int unsigned ones_left;
    int unsigned zeros_left;
    logic        b;

    ones_left  = 0;
    zeros_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset config: a partial block, then a clear that throws it away
    send_pattern(16'b1011, 4);
    send_item(KIND_CLEAR, 1'b1);
    drain();

    // Template written as zero clamps to 2; four ones give three windows
    write_cfg(16'hFFE0, 16'd4);
    send_pattern(16'hF, 4);
    drain();

    // Template written as 31 clamps to 21; block shorter than template
    write_cfg(16'h001F, 16'd3);
    send_pattern(16'h7, 3);
    drain();

    // Template shrinks mid-block: run is clamped, counting goes on to class many
    write_cfg(16'd5, 16'd12);
    send_pattern(16'hF, 4);
    drain();
    write_cfg(16'd2, 16'd12);
    send_pattern(16'hFF, 8);
    drain();

    // Block length lowered below the position: block closes on the next bit
    send_pattern(16'b110, 3);
    drain();
    write_cfg(16'd2, 16'd2);
    send_item(KIND_DATA, 1'b1);

    // Short blocks without pause across the receiver hold-off: the row fills
    // and the input stalls.
    drain();
    write_cfg(16'd2, 16'd3);
    repeat (PRESSURE_ITEMS) send_item(KIND_DATA, 1'($urandom_range(1)));

    // Random phases: new settings at each phase start, bits in runs of ones
    // with noise and the odd clear. Phases end mid-block on purpose.
    while (items_sent < ITEM_TARGET) begin
      drain();
      pick = $urandom_range(99);
      if (pick < 50) tpl_word = 16'($urandom);
      else tpl_word = 16'($urandom_range(2, 8));
      pick = $urandom_range(99);
      if (pick < 8) blk_word = 16'd1;
      else if (pick < 12) blk_word = 16'hFFFF;
      else if (pick < 16) blk_word = 16'($urandom);
      else blk_word = 16'($urandom_range(2, 40));
      write_cfg(tpl_word, blk_word);
      burst = (blk_word > 40 || blk_word == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(30, 120);
      repeat (burst) begin
        if ($urandom_range(99) < 2) begin
          send_item(KIND_CLEAR, 1'($urandom_range(1)));
        end else begin
          if (ones_left == 0 && zeros_left == 0) begin
            ones_left  = $urandom_range(0, 24);
            zeros_left = $urandom_range(1, 3);
          end
          if ($urandom_range(9) == 0) begin
            b = 1'($urandom_range(1));
          end else if (ones_left != 0) begin
            b = 1'b1;
            ones_left--;
          end else begin
            b = 1'b0;
            zeros_left--;
          end
          send_item(KIND_DATA, b);
        end
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #24_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
